// ----- rtl/lafi_pkg.sv -----
// Shared types and constants for the launch arm and fire interlock.
`default_nettype none

package lafi_pkg;

    localparam int SERIAL_W = 16;
    localparam int TICK_W   = 16;
    localparam int CHAN_W   = 8;
    localparam int STAT_W   = 2;
    localparam int SKEW_W   = 15;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 16;

    localparam logic [SKEW_W-1:0] SKEW_RESET   = SKEW_W'(10);
    localparam logic [TICK_W-1:0] WINDOW_RESET = TICK_W'(2000);
    localparam logic [TICK_W-1:0] PULSE_RESET  = TICK_W'(50);

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_QUERY  = 3'd1,
        OP_ARM    = 3'd2,
        OP_FIRE   = 3'd3,
        OP_MANUAL = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        OC_NONE     = 4'd0,
        OC_ANSWERED = 4'd1,
        OC_ARMED    = 4'd2,
        OC_FIRED    = 4'd3,
        OC_SERIAL   = 4'd4,
        OC_CHANNEL  = 4'd5,
        OC_UNARMED  = 4'd6,
        OC_LATE     = 4'd7,
        OC_SKEW     = 4'd8
    } t_outcome;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_SERIAL = 2'd0,
        CFG_SKEW   = 2'd1,
        CFG_WINDOW = 2'd2,
        CFG_PULSE  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [2:0]          op;
        logic [SERIAL_W-1:0] serial;
        logic [CHAN_W-1:0]   channel;
        logic [TICK_W-1:0]   tick;
        logic [STAT_W-1:0]   drogue;
        logic [STAT_W-1:0]   main;
    } t_cmd;

    typedef struct packed {
        logic [SERIAL_W-1:0] own_serial;
        logic [SKEW_W-1:0]   skew_tol;
        logic [TICK_W-1:0]   window;
        logic [TICK_W-1:0]   pulse;
    } t_cfg;

    typedef struct packed {
        logic [TICK_W-1:0] local_time;
        logic              armed;
        logic [TICK_W-1:0] arm_stamp;
        logic              pending;
        logic              firing;
        logic [TICK_W-1:0] pulse_left;
    } t_state;

    typedef struct packed {
        logic              reply_send;
        logic              reply_valid;
        logic [STAT_W-1:0] reply_arm_status;
        logic [STAT_W-1:0] reply_igniter_status;
        logic [TICK_W-1:0] reply_tick;
        logic [CHAN_W-1:0] reply_channel;
        logic              fire_drive;
        logic              is_armed;
        t_outcome          outcome;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/lafi_eval.sv -----
// Evaluation of one command against the interlock state.
`default_nettype none

module lafi_eval
    import lafi_pkg::*;
(
    input  var t_cmd    i_cmd,
    input  var t_cfg    i_cfg,
    input  var t_state  i_state,
    output t_state      o_state,
    output t_result     o_result
);

    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] diff;
    logic [TICK_W:0]   neg_diff;
    logic [TICK_W-1:0] skew_mag;
    logic              skew_ok;
    logic [TICK_W-1:0] since_arm;
    logic              late;
    logic [TICK_W-1:0] left_dec;
    logic              serial_ok;
    t_state            st;
    t_result           res;

    assign period    = (i_cfg.pulse == '0) ? TICK_W'(1) : i_cfg.pulse;
    assign diff      = i_cmd.tick - i_state.local_time;
    assign neg_diff  = (TICK_W+1)'(1 << TICK_W) - {1'b0, diff};
    assign skew_mag  = diff[TICK_W-1] ? neg_diff[TICK_W-1:0] : diff;
    assign skew_ok   = {1'b0, skew_mag} <= {2'b0, i_cfg.skew_tol};
    assign since_arm = i_state.local_time - i_state.arm_stamp;
    assign late      = since_arm > i_cfg.window;
    assign left_dec  = (i_state.pulse_left != '0) ? i_state.pulse_left - TICK_W'(1)
                                                  : i_state.pulse_left;
    assign serial_ok = i_cmd.serial == i_cfg.own_serial;

    always_comb begin
        st  = i_state;
        res = '0;
        res.outcome = OC_NONE;
        case (i_cmd.op)
            OP_TICK: begin
                st.local_time = i_state.local_time + TICK_W'(1);
                if (i_state.firing) begin
                    st.pulse_left = left_dec;
                    if (left_dec == '0) begin
                        if (i_state.pending) begin
                            st.pending    = 1'b0;
                            st.pulse_left = period;
                        end else begin
                            st.firing = 1'b0;
                        end
                    end
                end
            end
            OP_QUERY: begin
                if (!serial_ok) begin
                    res.outcome = OC_SERIAL;
                end else begin
                    res.reply_send = 1'b1;
                    if (i_cmd.channel == '0) begin
                        res.reply_valid          = 1'b1;
                        res.reply_arm_status     = i_cmd.drogue;
                        res.reply_igniter_status = i_cmd.main;
                    end
                    res.reply_tick    = i_state.local_time;
                    res.reply_channel = i_cmd.channel;
                    res.outcome       = OC_ANSWERED;
                end
            end
            OP_ARM: begin
                if (!serial_ok) begin
                    res.outcome = OC_SERIAL;
                end else if (i_cmd.channel != '0) begin
                    res.outcome = OC_CHANNEL;
                end else if (!skew_ok) begin
                    res.outcome = OC_SKEW;
                end else begin
                    st.armed     = 1'b1;
                    st.arm_stamp = i_state.local_time;
                    res.outcome  = OC_ARMED;
                end
            end
            OP_FIRE, OP_MANUAL: begin
                if (i_cmd.op == OP_FIRE && !i_state.armed) begin
                    res.outcome = OC_UNARMED;
                end else if (i_cmd.op == OP_FIRE && late) begin
                    res.outcome = OC_LATE;
                end else if (i_cmd.op == OP_FIRE && !skew_ok) begin
                    res.outcome = OC_SKEW;
                end else begin
                    if (!i_state.firing) begin
                        st.firing     = 1'b1;
                        st.pending    = 1'b0;
                        st.pulse_left = period;
                    end else begin
                        st.pending = 1'b1;
                    end
                    res.outcome = OC_FIRED;
                end
            end
            default: begin
            end
        endcase
        res.fire_drive = st.firing;
        res.is_armed   = st.armed;
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

`default_nettype wire

// ----- rtl/launch_arm_fire_interlock_unit.sv -----
// Launch arm and fire interlock: top level with input and result registers.
// Two register stages, command then result; one evaluation pass per item.
// Throughput: one item per cycle while i_out_ready is high.
// Reset: synchronous active low; clears state, flags and valids, and loads
// the register defaults (serial 0, skew 10, window 2000, pulse 50).
`default_nettype none

module launch_arm_fire_interlock_unit
    import lafi_pkg::*;
(
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_cfg_we,
    input  var logic [CFG_IX_W-1:0] i_cfg_index,
    input  var logic [CFG_D_W-1:0]  i_cfg_data,
    input  var logic                i_in_valid,
    output logic                    o_in_ready,
    input  var logic [2:0]          i_operation,
    input  var logic [SERIAL_W-1:0] i_cmd_serial,
    input  var logic [CHAN_W-1:0]   i_cmd_channel,
    input  var logic [TICK_W-1:0]   i_cmd_tick,
    input  var logic [STAT_W-1:0]   i_drogue_status,
    input  var logic [STAT_W-1:0]   i_main_status,
    output logic                    o_out_valid,
    input  var logic                i_out_ready,
    output logic                    o_reply_send,
    output logic                    o_reply_valid,
    output logic [STAT_W-1:0]       o_reply_arm_status,
    output logic [STAT_W-1:0]       o_reply_igniter_status,
    output logic [TICK_W-1:0]       o_reply_tick,
    output logic [CHAN_W-1:0]       o_reply_channel,
    output logic                    o_fire_drive,
    output logic                    o_is_armed,
    output logic [3:0]              o_outcome
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_cmd    r_cmd;
    logic    r_cmd_valid;
    t_result r_res;
    t_result n_res;
    logic    r_res_valid;
    logic    advance;

    assign advance    = r_cmd_valid && (!r_res_valid || i_out_ready);
    assign o_in_ready = !r_cmd_valid || advance;

    lafi_eval u_eval (
        .i_cmd    (r_cmd),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_serial <= '0;
            r_cfg.skew_tol   <= SKEW_RESET;
            r_cfg.window     <= WINDOW_RESET;
            r_cfg.pulse      <= PULSE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SERIAL: r_cfg.own_serial <= i_cfg_data;
                CFG_SKEW:   r_cfg.skew_tol   <= i_cfg_data[SKEW_W-1:0];
                CFG_WINDOW: r_cfg.window     <= i_cfg_data;
                CFG_PULSE:  r_cfg.pulse      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_cmd_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_cmd.op      <= i_operation;
            r_cmd.serial  <= i_cmd_serial;
            r_cmd.channel <= i_cmd_channel;
            r_cmd.tick    <= i_cmd_tick;
            r_cmd.drogue  <= i_drogue_status;
            r_cmd.main    <= i_main_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_res_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_res_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid            = r_res_valid;
    assign o_reply_send           = r_res.reply_send;
    assign o_reply_valid          = r_res.reply_valid;
    assign o_reply_arm_status     = r_res.reply_arm_status;
    assign o_reply_igniter_status = r_res.reply_igniter_status;
    assign o_reply_tick           = r_res.reply_tick;
    assign o_reply_channel        = r_res.reply_channel;
    assign o_fire_drive           = r_res.fire_drive;
    assign o_is_armed             = r_res.is_armed;
    assign o_outcome              = r_res.outcome;

endmodule

`default_nettype wire

// ----- dv/interlock_shadow_pkg.sv -----
// Shadow copy of the launch interlock state, with the queue of predicted results and their check.
package interlock_shadow_pkg;
    import lafi_pkg::*;

    class interlock_shadow;
        logic [SERIAL_W-1:0] serial_id;
        logic [SKEW_W-1:0]   skew_limit;
        logic [TICK_W-1:0]   window;
        logic [TICK_W-1:0]   pulse_len;
        logic [TICK_W-1:0]   clock_now;
        logic                armed;
        logic [TICK_W-1:0]   armed_at;
        logic                refire;
        logic                driving;
        logic [TICK_W-1:0]   ticks_left;
        t_result             due_results [$];
        int unsigned         results_seen;
        int unsigned         mismatch_count;

        function new();
            serial_id      = '0;
            skew_limit     = SKEW_RESET;
            window         = WINDOW_RESET;
            pulse_len      = PULSE_RESET;
            clock_now      = '0;
            armed          = 1'b0;
            armed_at       = '0;
            refire         = 1'b0;
            driving        = 1'b0;
            ticks_left     = '0;
            results_seen   = 0;
            mismatch_count = 0;
        endfunction

        function void write_register(t_cfg_index ix, logic [CFG_D_W-1:0] data);
            case (ix)
                CFG_SERIAL: serial_id  = data;
                CFG_SKEW:   skew_limit = data[SKEW_W-1:0];
                CFG_WINDOW: window     = data;
                CFG_PULSE:  pulse_len  = data;
                default: ;
            endcase
        endfunction

        function logic [TICK_W-1:0] period_ticks();
            return (pulse_len == '0) ? TICK_W'(1) : pulse_len;
        endfunction

        function bit within_skew(logic [TICK_W-1:0] stamp);
            logic [TICK_W-1:0] diff;
            logic [TICK_W:0]   mag;
            diff = stamp - clock_now;
            mag  = diff[TICK_W-1] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
            return mag <= {2'b00, skew_limit};
        endfunction

        function void start_or_queue_fire();
            if (!driving) begin
                driving    = 1'b1;
                refire     = 1'b0;
                ticks_left = period_ticks();
            end else begin
                refire = 1'b1;
            end
        endfunction

        function void take_command(t_cmd c);
            t_result           r;
            logic [TICK_W-1:0] elapsed;
            r = '0;
            case (c.op)
                OP_TICK: begin
                    clock_now = clock_now + TICK_W'(1);
                    if (driving) begin
                        if (ticks_left != '0)
                            ticks_left = ticks_left - TICK_W'(1);
                        if (ticks_left == '0) begin
                            if (refire) begin
                                refire     = 1'b0;
                                ticks_left = period_ticks();
                            end else begin
                                driving = 1'b0;
                            end
                        end
                    end
                end
                OP_QUERY: begin
                    if (c.serial != serial_id) begin
                        r.outcome = OC_SERIAL;
                    end else begin
                        r.reply_send = 1'b1;
                        if (c.channel == '0) begin
                            r.reply_valid          = 1'b1;
                            r.reply_arm_status     = c.drogue;
                            r.reply_igniter_status = c.main;
                        end
                        r.reply_tick    = clock_now;
                        r.reply_channel = c.channel;
                        r.outcome       = OC_ANSWERED;
                    end
                end
                OP_ARM: begin
                    if (c.serial != serial_id) begin
                        r.outcome = OC_SERIAL;
                    end else if (c.channel != '0) begin
                        r.outcome = OC_CHANNEL;
                    end else if (!within_skew(c.tick)) begin
                        r.outcome = OC_SKEW;
                    end else begin
                        armed     = 1'b1;
                        armed_at  = clock_now;
                        r.outcome = OC_ARMED;
                    end
                end
                OP_FIRE: begin
                    elapsed = clock_now - armed_at;
                    if (!armed) begin
                        r.outcome = OC_UNARMED;
                    end else if (elapsed > window) begin
                        r.outcome = OC_LATE;
                    end else if (!within_skew(c.tick)) begin
                        r.outcome = OC_SKEW;
                    end else begin
                        start_or_queue_fire();
                        r.outcome = OC_FIRED;
                    end
                end
                OP_MANUAL: begin
                    start_or_queue_fire();
                    r.outcome = OC_FIRED;
                end
                default: ;
            endcase
            r.fire_drive = driving;
            r.is_armed   = armed;
            due_results.push_back(r);
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatch_count++;
            $display("result %0d: %s got 0x%0h, want 0x%0h",
                     results_seen, what, got, want);
        endtask

        task match_result(t_result got);
            t_result want;
            results_seen++;
            if (due_results.size() == 0) begin
                flag_mismatch("result with nothing due, outcome", got.outcome, 0);
                return;
            end
            want = due_results.pop_front();
            if (got.reply_send !== want.reply_send)
                flag_mismatch("reply_send", got.reply_send, want.reply_send);
            if (got.reply_valid !== want.reply_valid)
                flag_mismatch("reply_valid", got.reply_valid, want.reply_valid);
            if (got.reply_arm_status !== want.reply_arm_status)
                flag_mismatch("reply_arm_status", got.reply_arm_status, want.reply_arm_status);
            if (got.reply_igniter_status !== want.reply_igniter_status)
                flag_mismatch("reply_igniter_status", got.reply_igniter_status,
                              want.reply_igniter_status);
            if (got.reply_tick !== want.reply_tick)
                flag_mismatch("reply_tick", got.reply_tick, want.reply_tick);
            if (got.reply_channel !== want.reply_channel)
                flag_mismatch("reply_channel", got.reply_channel, want.reply_channel);
            if (got.fire_drive !== want.fire_drive)
                flag_mismatch("fire_drive", got.fire_drive, want.fire_drive);
            if (got.is_armed !== want.is_armed)
                flag_mismatch("is_armed", got.is_armed, want.is_armed);
            if (got.outcome !== want.outcome)
                flag_mismatch("outcome", got.outcome, want.outcome);
        endtask
    endclass

endpackage

// ----- dv/launch_arm_fire_interlock_unit_tb.sv -----
// Testbench top for the launch arm and fire interlock: stimulus, result sink and watchdog.
module launch_arm_fire_interlock_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lafi_pkg::*;
    import interlock_shadow_pkg::*;

    localparam int          HOLD_CYCLES    = 64;
    localparam int          QUIET_LIMIT    = 2000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          PHASE_ITEMS    = 230;
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [CFG_IX_W-1:0] cfg_index   = '0;
    logic [CFG_D_W-1:0]  cfg_data    = '0;
    logic                in_valid    = 1'b0;
    t_cmd                cmd         = '0;
    logic                out_ready   = 1'b0;
    bit                  sender_idle = 1'b1;
    bit                  sink_idle   = 1'b1;
    bit                  hold_off    = 1'b0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_reply_send;
    logic                o_reply_valid;
    logic [STAT_W-1:0]   o_reply_arm_status;
    logic [STAT_W-1:0]   o_reply_igniter_status;
    logic [TICK_W-1:0]   o_reply_tick;
    logic [CHAN_W-1:0]   o_reply_channel;
    logic                o_fire_drive;
    logic                o_is_armed;
    logic [3:0]          o_outcome;

    interlock_shadow     shadow;

    launch_arm_fire_interlock_unit dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_data             (cfg_data),
        .i_in_valid             (in_valid),
        .o_in_ready             (o_in_ready),
        .i_operation            (cmd.op),
        .i_cmd_serial           (cmd.serial),
        .i_cmd_channel          (cmd.channel),
        .i_cmd_tick             (cmd.tick),
        .i_drogue_status        (cmd.drogue),
        .i_main_status          (cmd.main),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (out_ready),
        .o_reply_send           (o_reply_send),
        .o_reply_valid          (o_reply_valid),
        .o_reply_arm_status     (o_reply_arm_status),
        .o_reply_igniter_status (o_reply_igniter_status),
        .o_reply_tick           (o_reply_tick),
        .o_reply_channel        (o_reply_channel),
        .o_fire_drive           (o_fire_drive),
        .o_is_armed             (o_is_armed),
        .o_outcome              (o_outcome)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_cmd command(logic [2:0] op, logic [SERIAL_W-1:0] serial,
                                     logic [CHAN_W-1:0] channel, logic [TICK_W-1:0] tick,
                                     logic [STAT_W-1:0] drogue, logic [STAT_W-1:0] main);
        t_cmd c;
        c.op      = op;
        c.serial  = serial;
        c.channel = channel;
        c.tick    = tick;
        c.drogue  = drogue;
        c.main    = main;
        return c;
    endfunction

    function automatic t_cmd random_command();
        t_cmd        c;
        int unsigned pick;
        int          span;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.op = OP_TICK;
        else if (pick < 55)
            c.op = OP_QUERY;
        else if (pick < 70)
            c.op = OP_ARM;
        else if (pick < 90)
            c.op = OP_FIRE;
        else if (pick < 95)
            c.op = OP_MANUAL;
        else
            c.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        c.serial  = ($urandom_range(0, 99) < 85) ? shadow.serial_id : SERIAL_W'($urandom);
        c.channel = ($urandom_range(0, 99) < 80) ? CHAN_W'(0) : CHAN_W'($urandom);
        span = int'(shadow.skew_limit) + 3;
        if ($urandom_range(0, 99) < 70)
            c.tick = shadow.clock_now + TICK_W'(int'($urandom_range(0, 2 * span)) - span);
        else
            c.tick = TICK_W'($urandom);
        c.drogue = STAT_W'($urandom);
        c.main   = STAT_W'($urandom);
        return c;
    endfunction

    task automatic send_command(input t_cmd c);
        int gap;
        gap = sender_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shadow.take_command(c);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (shadow.due_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic program_config(input logic [CFG_D_W-1:0] serial, skew, window, pulse);
        t_cfg_index         order [4];
        logic [CFG_D_W-1:0] vals [4];
        order = '{CFG_SERIAL, CFG_SKEW, CFG_WINDOW, CFG_PULSE};
        vals  = '{serial, skew, window, pulse};
        foreach (order[i]) begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            shadow.write_register(order[i], vals[i]);
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_D_W-1:0] serial, skew, window, pulse,
                             input bit idle_in, idle_out, pressure);
        program_config(serial, skew, window, pulse);
        sender_idle = idle_in;
        sink_idle   = idle_out;
        hold_off    = pressure;
        repeat (PHASE_ITEMS) send_command(random_command());
        wait_drained();
    endtask

    initial begin : stimulus
        shadow = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_command(command(OP_QUERY, 16'hFFFF, 8'h00, 16'h0000, 2'd3, 2'd3));
        send_command(command(OP_QUERY, 16'h0000, 8'h00, 16'hFFFF, 2'd3, 2'd3));
        send_command(command(OP_QUERY, 16'h0000, 8'hFF, 16'h0000, 2'd0, 2'd0));
        send_command(command(OP_FIRE, 16'hFFFF, 8'hFF, 16'h0000, 2'd1, 2'd2));
        send_command(command(OP_ARM, 16'hFFFF, 8'h00, 16'h0000, 2'd0, 2'd0));
        send_command(command(OP_ARM, 16'h0000, 8'h01, 16'h0000, 2'd0, 2'd0));
        send_command(command(OP_ARM, 16'h0000, 8'h00, 16'd11, 2'd0, 2'd0));
        send_command(command(OP_ARM, 16'h0000, 8'h00, 16'hFFF6, 2'd0, 2'd0));
        send_command(command(OP_FIRE, 16'h0000, 8'h00, 16'h8000, 2'd0, 2'd0));
        send_command(command(OP_SPARE_FIRST, 16'hFFFF, 8'hFF, 16'hFFFF, 2'd3, 2'd3));
        send_command(command(OP_SPARE_LAST, 16'h0000, 8'h00, 16'h0000, 2'd0, 2'd0));
        wait_drained();

        program_config(16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000);
        send_command(command(OP_FIRE, 16'h0000, 8'h00, 16'h8000, 2'd0, 2'd0));
        send_command(command(OP_FIRE, 16'hFFFF, 8'hAA, 16'h7FFF, 2'd0, 2'd0));
        send_command(command(OP_FIRE, 16'h1234, 8'h00, 16'h0000, 2'd0, 2'd0));
        send_command(command(OP_MANUAL, 16'h0000, 8'h55, 16'h1111, 2'd2, 2'd1));
        send_command(command(OP_TICK, 16'h0000, 8'h00, 16'h0000, 2'd0, 2'd0));
        send_command(command(OP_TICK, 16'h0000, 8'h00, 16'h0000, 2'd0, 2'd0));
        send_command(command(OP_FIRE, 16'hFFFF, 8'h00, 16'h0002, 2'd0, 2'd0));
        send_command(command(OP_ARM, 16'hFFFF, 8'h00, 16'h8001, 2'd0, 2'd0));
        send_command(command(OP_QUERY, 16'hFFFF, 8'h00, 16'h0000, 2'd1, 2'd2));
        send_command(command(OP_FIRE, 16'hFFFF, 8'h00, 16'h0002, 2'd0, 2'd0));
        send_command(command(OP_TICK, 16'h0000, 8'h00, 16'h0000, 2'd0, 2'd0));
        wait_drained();

        run_phase(16'h0000, 16'd10, 16'd2000, 16'd50, 1'b1, 1'b1, 1'b0);
        run_phase(16'($urandom), 16'd0, 16'd30, 16'd3, 1'b1, 1'b1, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        run_phase(16'($urandom), 16'($urandom_range(0, 40)), 16'($urandom_range(0, 200)),
                  16'd0, 1'b0, 1'b0, 1'b1);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  1'b1, 1'b1, 1'b0);
        run_phase(16'($urandom), 16'd5, 16'd100, 16'd1, 1'b0, 1'b1, 1'b0);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (shadow.mismatch_count == 0)
            $display("launch_arm_fire_interlock_unit regression: pass");
        else
            $display("launch_arm_fire_interlock_unit regression: fail");
        $finish;
    end

    initial begin : result_sink
        int      stall;
        t_result got;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end else begin
                stall = sink_idle ? $urandom_range(0, 5) : 0;
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.reply_send           = o_reply_send;
            got.reply_valid          = o_reply_valid;
            got.reply_arm_status     = o_reply_arm_status;
            got.reply_igniter_status = o_reply_igniter_status;
            got.reply_tick           = o_reply_tick;
            got.reply_channel        = o_reply_channel;
            got.fire_drive           = o_fire_drive;
            got.is_armed             = o_is_armed;
            got.outcome              = t_outcome'(o_outcome);
            shadow.match_result(got);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("launch_arm_fire_interlock_unit regression: fail");
        $finish;
    end

endmodule
